### rtl/core/assert_macros.svh
// Assertion helpers for the core RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

### rtl/core/imsu_pkg.sv
package imsu_pkg;

  // Lattice side length used when the top level is not overridden.
  localparam int SIDE_DEFAULT = 128;

  // Field widths of the item and result ports and of the acceptance thresholds.
  localparam int SITE_W   = 14;
  localparam int RAND_W   = 32;
  localparam int PROB_W   = 33;
  localparam int DE_W     = 5;
  localparam int ENERGY_W = 17;
  localparam int COUNT_W  = 15;

  // Configuration port widths.
  localparam int APB_DW = 64;
  localparam int APB_AW = 4;

  // Acceptance thresholds reset to one, which means always accept.
  localparam logic [PROB_W-1:0] PROB_RESET = {1'b1, {(PROB_W-1){1'b0}}};

endpackage

### rtl/core/ising_metropolis_spin_update.sv
// Sequence: an accepted start runs the divide and split steps, five lattice reads,
// a wait state for the read data, decide and commit; done then shows the result.
// start may be taken in the cycle that shows done. A site outside the lattice goes from split straight to commit.
// Reset (rst, synchronous) is followed by a clearing pass that zeroes all SIDE*SIDE
// sites (16384 at SIDE = 128) with busy high; configuration writes are taken meanwhile.
// Results are strobed for one cycle on done; the receiver cannot stall.
module ising_metropolis_spin_update #(
  parameter int SIDE = imsu_pkg::SIDE_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Item port.
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 func,
  input  logic [imsu_pkg::SITE_W-1:0]          site,
  input  logic                                 new_spin,
  input  logic [imsu_pkg::RAND_W-1:0]          rand_frac,
  // Result port.
  output logic                                 done,
  output logic                                 flipped,
  output logic                                 spin_after,
  output logic signed [imsu_pkg::DE_W-1:0]     energy_change,
  output logic signed [imsu_pkg::ENERGY_W-1:0] energy_now,
  output logic [imsu_pkg::COUNT_W-1:0]         up_count,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [imsu_pkg::APB_AW-1:0]          paddr,
  input  logic [imsu_pkg::APB_DW-1:0]          pwdata,
  output logic [imsu_pkg::APB_DW-1:0]          prdata,
  output logic                                 pready
);

  // Lattice geometry. Sites are numbered x + y*SIDE.
  localparam int CELLS = SIDE * SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(SIDE);

  // The row index y = site / SIDE is taken as (site * RECIP) >> RECIP_K.
  // With RECIP_K = 26 the rounding error stays below one for every 14-bit site
  // and every side length up to 1024, so the quotient is exact.
  localparam int RECIP_K = 26;
  localparam int RECIP   = (1 << RECIP_K) / SIDE + 1;
  localparam int PW      = RECIP_K + imsu_pkg::SITE_W;

  localparam logic signed [imsu_pkg::ENERGY_W-1:0] ENERGY_RESET =
    imsu_pkg::ENERGY_W'(-2 * CELLS);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_SPLIT  = 3'd3;
  localparam logic [2:0] ST_READ   = 3'd4;
  localparam logic [2:0] ST_WAIT   = 3'd5;
  localparam logic [2:0] ST_DECIDE = 3'd6;
  localparam logic [2:0] ST_COMMIT = 3'd7;

  // Order in which the five lattice reads are issued.
  localparam logic [2:0] NB_CENTER = 3'd0;
  localparam logic [2:0] NB_RIGHT  = 3'd1;
  localparam logic [2:0] NB_LEFT   = 3'd2;
  localparam logic [2:0] NB_UP     = 3'd3;
  localparam logic [2:0] NB_DOWN   = 3'd4;

  // Configuration registers live at byte addresses 0 and 8. Only address bit 3
  // is decoded, so the lower address bits alias.
  localparam logic REG_COST4 = 1'b0;
  localparam logic REG_COST8 = 1'b1;

  logic [2:0]                          state;
  logic [2:0]                          state_next;
  logic [AW-1:0]                       clr_addr;

  // Latched item.
  logic                                func_r;
  logic [imsu_pkg::SITE_W-1:0]         site_r;
  logic                                want_r;
  logic [imsu_pkg::RAND_W-1:0]         rnd_r;

  // Coordinate split.
  logic [PW-1:0]                       prod;
  logic [imsu_pkg::SITE_W-1:0]         y_full;
  logic [imsu_pkg::SITE_W-1:0]         x_full;
  logic                                site_ok;
  logic [XW-1:0]                       x_r;
  logic [XW-1:0]                       y_r;

  // Lattice reads.
  logic [2:0]                          rd_idx;
  logic                                rd_valid;
  logic [2:0]                          rd_tag;
  logic                                center_s;
  logic [2:0]                          nup;
  logic [AW-1:0]                       site_a;
  logic [AW-1:0]                       nb_addr;

  // Decision.
  logic signed [imsu_pkg::DE_W-1:0]    nb_sum;
  logic signed [imsu_pkg::DE_W-1:0]    de_up;
  logic signed [imsu_pkg::DE_W-1:0]    de_calc;
  logic                                flip_calc;
  logic [imsu_pkg::PROB_W-1:0]         thresh;
  logic                                flip_r;
  logic signed [imsu_pkg::DE_W-1:0]    de_r;

  // Running totals.
  logic signed [imsu_pkg::ENERGY_W-1:0] energy;
  logic [imsu_pkg::COUNT_W-1:0]        ups;

  // Thresholds.
  logic [imsu_pkg::PROB_W-1:0]         cost4;
  logic [imsu_pkg::PROB_W-1:0]         cost8;
  logic                                cfg_wr;

  // Lattice memory, one bit per site, single port with registered read data.
  logic                                mem [CELLS];
  logic [AW-1:0]                       mem_addr;
  logic                                mem_we;
  logic                                mem_wdata;
  logic                                mem_rdata;

  assign busy       = (state != ST_IDLE);
  assign energy_now = energy;
  assign up_count   = ups;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; reads return the
  // addressed threshold zero-extended to the bus width.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[3] == REG_COST8) ? imsu_pkg::APB_DW'(cost8)
                                          : imsu_pkg::APB_DW'(cost4);

  always_ff @(posedge clk) begin
    if (rst) begin
      cost4 <= imsu_pkg::PROB_RESET;
      cost8 <= imsu_pkg::PROB_RESET;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_COST4) begin
        cost4 <= pwdata[imsu_pkg::PROB_W-1:0];
      end else begin
        cost8 <= pwdata[imsu_pkg::PROB_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Coordinate split. The product is registered in the divide step; the split
  // step turns it into the row index and recovers the column with one constant
  // multiply. Both are only meaningful for sites inside the lattice.
  // ---------------------------------------------------------------------------
  assign y_full  = prod[RECIP_K +: imsu_pkg::SITE_W];
  assign x_full  = site_r - y_full * imsu_pkg::SITE_W'(SIDE);
  assign site_ok = (32'(site_r) < 32'(CELLS));
  assign site_a  = AW'(site_r);

  // Neighbor addresses follow from the site by adding or subtracting a stride,
  // with the periodic wrap taken at the lattice edges.
  always_comb begin
    unique case (rd_idx)
      NB_CENTER: nb_addr = site_a;
      NB_RIGHT:  nb_addr = (x_r == XW'(SIDE - 1)) ? site_a - AW'(SIDE - 1)
                                                  : site_a + AW'(1);
      NB_LEFT:   nb_addr = (x_r == '0) ? site_a + AW'(SIDE - 1)
                                       : site_a - AW'(1);
      NB_UP:     nb_addr = (y_r == XW'(SIDE - 1)) ? site_a - AW'((SIDE - 1) * SIDE)
                                                  : site_a + AW'(SIDE);
      default:   nb_addr = (y_r == '0) ? site_a + AW'((SIDE - 1) * SIDE)
                                       : site_a - AW'(SIDE);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Energy change and acceptance. The neighbor sum is 2*nup - 4, and
  // dE = 2*s*sum, so dE is one of -8, -4, 0, 4, 8. Positive costs are compared
  // against the matching threshold when func is high; a threshold with its top
  // bit set always accepts, since a 32-bit fraction is always below it.
  // ---------------------------------------------------------------------------
  assign nb_sum  = $signed({1'b0, nup, 1'b0}) - imsu_pkg::DE_W'(4);
  assign de_up   = nb_sum <<< 1;
  assign de_calc = center_s ? de_up : -de_up;
  assign thresh  = (de_calc == imsu_pkg::DE_W'(4)) ? cost4 : cost8;

  always_comb begin
    if (func_r) begin
      flip_calc = de_calc[imsu_pkg::DE_W-1] || (de_calc == '0) ||
                  ({1'b0, rnd_r} < thresh);
    end else begin
      flip_calc = (center_s != want_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Lattice memory port. The clearing pass after reset owns it first; after
  // that, reads are issued in the read state and the single write, if the spin
  // flips, happens in the commit state.
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (state)
      ST_CLEAR: mem_addr = clr_addr;
      ST_READ:  mem_addr = nb_addr;
      default:  mem_addr = site_a;
    endcase
  end

  assign mem_we    = (state == ST_CLEAR) || ((state == ST_COMMIT) && flip_r);
  assign mem_wdata = (state == ST_CLEAR) ? 1'b0 : !center_s;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_addr];
  end

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == AW'(CELLS - 1)) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_DIV;
      ST_DIV:    state_next = ST_SPLIT;
      ST_SPLIT:  state_next = site_ok ? ST_READ : ST_COMMIT;
      ST_READ:   if (rd_idx == NB_DOWN) state_next = ST_WAIT;
      ST_WAIT:   state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
      energy   <= ENERGY_RESET;
      ups      <= '0;
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_READ);
      done     <= (state == ST_COMMIT);
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if ((state == ST_COMMIT) && flip_r) begin
        energy <= energy + imsu_pkg::ENERGY_W'(de_r);
        ups    <= center_s ? ups - imsu_pkg::COUNT_W'(1)
                           : ups + imsu_pkg::COUNT_W'(1);
      end
    end
  end

  // Datapath registers carry no reset; the sequencer decides when they count.
  always_ff @(posedge clk) begin
    rd_tag <= rd_idx;
    if ((state == ST_IDLE) && start) begin
      func_r <= func;
      site_r <= site;
      want_r <= new_spin;
      rnd_r  <= rand_frac;
    end
    if (state == ST_DIV) begin
      prod <= PW'(site_r) * PW'(RECIP);
    end
    if (state == ST_SPLIT) begin
      x_r    <= x_full[XW-1:0];
      y_r    <= y_full[XW-1:0];
      rd_idx <= NB_CENTER;
      nup    <= '0;
      // A site outside the lattice goes straight to commit as a no-op.
      flip_r   <= 1'b0;
      de_r     <= '0;
      center_s <= 1'b0;
    end
    if (state == ST_READ) begin
      rd_idx <= rd_idx + 3'd1;
    end
    // Read data lands in the cycle after its address; the first read is the site
    // itself, the other four are counted as up neighbors.
    if (rd_valid) begin
      if (rd_tag == NB_CENTER) begin
        center_s <= mem_rdata;
      end else begin
        nup <= nup + {2'b00, mem_rdata};
      end
    end
    if (state == ST_DECIDE) begin
      flip_r <= flip_calc;
      de_r   <= flip_calc ? de_calc : '0;
    end
    if (state == ST_COMMIT) begin
      flipped       <= flip_r;
      spin_after    <= center_s ^ flip_r;
      energy_change <= de_r;
    end
  end

`include "assert_macros.svh"

  // A result only appears once the sequencer is back and ready for the next item.
  `ASSERT_IMPLIES(a_done_idle, done, state == ST_IDLE)
  // An unchanged spin reports no energy change.
  `ASSERT_IMPLIES(a_noflip_zero_de, done && !flipped, energy_change == '0)
  // An accepted item always starts the coordinate split.
  `ASSERT_NEXT(a_start_div, start && !busy, state == ST_DIV)
  // Totals move only at commit.
  `ASSERT_NEXT(a_totals_hold, state != ST_COMMIT, $stable(energy_now) && $stable(up_count))

endmodule
